// ----- hdl/mtcg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI transport clock generator package
// Shared item types, realtime status codes and timing constants.
// ----------------------------------------------------------------------------
package mtcg_pkg;

  // Realtime status bytes.
  localparam logic [7:0] ST_CLOCK    = 8'hF8;
  localparam logic [7:0] ST_START    = 8'hFA;
  localparam logic [7:0] ST_CONTINUE = 8'hFB;
  localparam logic [7:0] ST_STOP     = 8'hFC;

  // Tempo limits and clock resolution.
  localparam int BPM_MIN     = 40;
  localparam int BPM_MAX     = 300;
  localparam int MS_PER_MIN  = 60000;
  localparam int PPQN        = 24;
  // 60000 / (bpm * 24) equals 2500 / bpm for integer bpm.
  localparam int BASE_DIVIDEND = MS_PER_MIN / PPQN;

  // Divider geometry: 14-bit dividend, 9-bit divisor.
  localparam int DVD_W    = 14;
  localparam int DSR_W    = 9;
  localparam int PERIOD_W = DVD_W;

  // Default catch-up limit per item.
  localparam int MAX_CLOCKS_DEFAULT = 63;

  // Command queue depth.
  localparam int QDEPTH = 2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ROUTE = 2'd0;
  localparam logic [1:0] CFG_TEMPO = 2'd1;
  localparam logic [1:0] CFG_NUM   = 2'd2;
  localparam logic [1:0] CFG_DEN   = 2'd3;

  // Transport event found by the front end.
  typedef enum logic [1:0] {
    XP_NONE,
    XP_START,
    XP_CONTINUE,
    XP_STOP
  } xport_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        is_playing;
    logic        is_running;
    logic        at_step_zero;
    logic        external_sync;
  } in_item_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic       last;
  } out_item_t;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    logic [31:0] now_ms;
    logic        playing;
    logic        set_sched;
    xport_t      xport;
  } cmd_t;

endpackage
`default_nettype wire

// ----- hdl/mtcg_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI transport clock front end
// Accepts time updates, drops suppressed ones, tracks the transport flags and
// classifies each update into a command for the back end.
// ----------------------------------------------------------------------------
module mtcg_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire mtcg_pkg::in_item_t in_data,
  output logic                    in_stall,
  input  wire logic [1:0]         route_select,
  input  wire logic               q_full,
  output logic                    push,
  output mtcg_pkg::cmd_t          cmd
);

  logic was_playing;
  logic was_running;
  logic play_rise;
  logic play_fall;

  // The queue being full is the only reason to hold off an item.
  assign in_stall = q_full;

  // An item with the route off or under external sync leaves no trace.
  assign push = in_valid && !q_full && (route_select != 2'd0) && !in_data.external_sync;

  assign play_rise = in_data.is_playing && !was_playing;
  assign play_fall = !in_data.is_playing && was_playing;

  // Build the command for the back end.
  always_comb begin
    cmd.now_ms    = in_data.now_ms;
    cmd.playing   = in_data.is_playing;
    cmd.set_sched = (in_data.is_running && !was_running) || play_rise;
    if (play_rise) begin
      cmd.xport = in_data.at_step_zero ? mtcg_pkg::XP_START : mtcg_pkg::XP_CONTINUE;
    end else if (play_fall) begin
      cmd.xport = mtcg_pkg::XP_STOP;
    end else begin
      cmd.xport = mtcg_pkg::XP_NONE;
    end
  end

  // Stored transport flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      was_playing <= 1'b0;
      was_running <= 1'b0;
    end else if (push) begin
      was_playing <= in_data.is_playing;
      was_running <= in_data.is_running;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mtcg_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI transport clock command queue
// Small FIFO of classified commands between the front and back ends.
// ----------------------------------------------------------------------------
module mtcg_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire mtcg_pkg::cmd_t push_data,
  input  wire logic           pop,
  output mtcg_pkg::cmd_t      pop_data,
  output logic                full,
  output logic                empty
);

  localparam int PTR_W = (mtcg_pkg::QDEPTH > 1) ? $clog2(mtcg_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(mtcg_pkg::QDEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(mtcg_pkg::QDEPTH - 1);

  mtcg_pkg::cmd_t   entries [mtcg_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(mtcg_pkg::QDEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mtcg_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI transport clock back end
// Works out the tick period with a shared serial divider, keeps the tick
// schedule and emits the transport and clock bytes through an output register.
// ----------------------------------------------------------------------------
module mtcg_back #(
  parameter int MAX_CLOCKS_PER_ITEM = mtcg_pkg::MAX_CLOCKS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_empty,
  input  wire mtcg_pkg::cmd_t      q_data,
  output logic                     pop,
  input  wire logic [15:0]         tempo_bpm,
  input  wire logic [7:0]          ratio_numerator,
  input  wire logic [7:0]          ratio_denominator,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mtcg_pkg::out_item_t      out_data
);

  localparam int CNT_W  = $clog2(MAX_CLOCKS_PER_ITEM + 1);
  localparam int STEP_W = $clog2(mtcg_pkg::DVD_W);
  localparam int DVD_W  = mtcg_pkg::DVD_W;
  localparam int DSR_W  = mtcg_pkg::DSR_W;
  localparam int PER_W  = mtcg_pkg::PERIOD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_PER,
    S_TRANS,
    S_CLK
  } state_t;

  state_t           state;
  mtcg_pkg::cmd_t   cmd;
  logic [31:0]      next_tick;
  logic [31:0]      diff;
  logic [PER_W-1:0] period;
  logic [CNT_W-1:0] clk_cnt;

  // Serial divider registers.
  logic [DSR_W-1:0]  div_rem;
  logic [DVD_W-1:0]  div_dvd;
  logic [DSR_W-1:0]  div_dsr;
  logic [STEP_W-1:0] div_step;
  logic              div_pass;

  logic [DSR_W:0]    trial;
  logic              trial_ge;
  logic [DSR_W-1:0]  rem_step;
  logic [DSR_W-1:0]  bpm_clamped;
  logic [7:0]        num_eff;
  logic [DVD_W-1:0]  mul_prod;
  logic [31:0]       sched_pick;
  logic [31:0]       sched_load;
  logic [31:0]       diff_sub;
  logic              slot;
  logic              emit;
  logic              last_trans;
  logic              last_clock;
  logic [7:0]        trans_byte;

  // One restoring division step per cycle; the remainder stays below the divisor.
  assign trial    = {div_rem, div_dvd[DVD_W-1]};
  assign trial_ge = (trial >= {1'b0, div_dsr});
  assign rem_step = trial_ge ? DSR_W'(trial - {1'b0, div_dsr}) : trial[DSR_W-1:0];

  // Tempo clamp and zero numerator guard.
  always_comb begin
    if (tempo_bpm < 16'(mtcg_pkg::BPM_MIN)) begin
      bpm_clamped = DSR_W'(mtcg_pkg::BPM_MIN);
    end else if (tempo_bpm > 16'(mtcg_pkg::BPM_MAX)) begin
      bpm_clamped = DSR_W'(mtcg_pkg::BPM_MAX);
    end else begin
      bpm_clamped = tempo_bpm[DSR_W-1:0];
    end
  end
  assign num_eff  = (ratio_numerator == 8'd0) ? 8'd1 : ratio_numerator;

  // The base period is at most 62, so six quotient bits carry it.
  assign mul_prod = DVD_W'(div_dvd[5:0]) * DVD_W'(ratio_denominator);

  // Schedule load at the start of a command.
  assign sched_pick = q_data.set_sched ? q_data.now_ms : next_tick;
  assign sched_load = (q_data.playing && (sched_pick == 32'd0)) ? q_data.now_ms : sched_pick;

  // Distance to the tick after the current one.
  assign diff_sub = diff - 32'(period);

  assign slot       = !out_valid || !out_stall;
  assign emit       = slot && ((state == S_TRANS) || ((state == S_CLK) && !diff[31]));
  assign pop        = (state == S_IDLE) && !q_empty;
  assign last_trans = !cmd.playing || diff[31];
  assign last_clock = (clk_cnt == CNT_W'(MAX_CLOCKS_PER_ITEM - 1)) || diff_sub[31];

  always_comb begin
    case (cmd.xport)
      mtcg_pkg::XP_START:    trans_byte = mtcg_pkg::ST_START;
      mtcg_pkg::XP_CONTINUE: trans_byte = mtcg_pkg::ST_CONTINUE;
      default:               trans_byte = mtcg_pkg::ST_STOP;
    endcase
  end

  // Sequencer, schedule and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      next_tick <= 32'd0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cmd       <= q_data;
            next_tick <= sched_load;
            div_rem   <= '0;
            div_dvd   <= DVD_W'(mtcg_pkg::BASE_DIVIDEND);
            div_dsr   <= bpm_clamped;
            div_step  <= '0;
            div_pass  <= 1'b0;
            if (q_data.playing) begin
              state <= S_DIV;
            end else if (q_data.xport == mtcg_pkg::XP_STOP) begin
              state <= S_TRANS;
            end
          end
        end
        S_DIV: begin
          div_rem  <= rem_step;
          div_dvd  <= {div_dvd[DVD_W-2:0], trial_ge};
          div_step <= div_step + STEP_W'(1);
          if (div_step == STEP_W'(DVD_W - 1)) begin
            state <= div_pass ? S_PER : S_MUL;
          end
        end
        S_MUL: begin
          div_dvd  <= mul_prod;
          div_rem  <= '0;
          div_dsr  <= {1'b0, num_eff};
          div_step <= '0;
          div_pass <= 1'b1;
          state    <= S_DIV;
        end
        S_PER: begin
          period  <= (div_dvd == '0) ? PER_W'(1) : div_dvd;
          diff    <= cmd.now_ms - next_tick;
          clk_cnt <= '0;
          state   <= (cmd.xport == mtcg_pkg::XP_NONE) ? S_CLK : S_TRANS;
        end
        S_TRANS: begin
          if (slot) begin
            out_data.status_byte <= trans_byte;
            out_data.last        <= last_trans;
            state                <= last_trans ? S_IDLE : S_CLK;
          end
        end
        S_CLK: begin
          if (diff[31]) begin
            state <= S_IDLE;
          end else if (slot) begin
            out_data.status_byte <= mtcg_pkg::ST_CLOCK;
            out_data.last        <= last_clock;
            next_tick            <= next_tick + 32'(period);
            diff                 <= diff_sub;
            clk_cnt              <= clk_cnt + CNT_W'(1);
            if (last_clock) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/midi_transport_clock_generator.sv -----
// A Stop-only item goes from the idle state straight to the transport state,
// which loads its byte into the output register; a playing item first passes
// through two 14-step serial divisions of the tick period in the back end.
// The back end works on one item at a time and takes the next only once it is
// back in idle; a two-entry queue buffers items in between.
// Reset (synchronous, active high) clears the flags, schedule and queue.
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI transport clock generator
// Emits Start, Continue, Stop and Clock realtime bytes, 24 per quarter at a 1:1 ratio, from
// millisecond time updates and transport flags.
// ----------------------------------------------------------------------------
module midi_transport_clock_generator #(
  parameter int MAX_CLOCKS_PER_ITEM = mtcg_pkg::MAX_CLOCKS_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire mtcg_pkg::in_item_t  in_data,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mtcg_pkg::out_item_t      out_data,
  input  wire logic                cfg_write,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_data
);

  logic [1:0]     route_select;
  logic [15:0]    tempo_bpm;
  logic [7:0]     ratio_numerator;
  logic [7:0]     ratio_denominator;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;
  mtcg_pkg::cmd_t push_cmd;
  mtcg_pkg::cmd_t pop_cmd;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      route_select      <= 2'd0;
      tempo_bpm         <= 16'd120;
      ratio_numerator   <= 8'd1;
      ratio_denominator <= 8'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        mtcg_pkg::CFG_ROUTE: route_select      <= cfg_data[1:0];
        mtcg_pkg::CFG_TEMPO: tempo_bpm         <= cfg_data;
        mtcg_pkg::CFG_NUM:   ratio_numerator   <= cfg_data[7:0];
        mtcg_pkg::CFG_DEN:   ratio_denominator <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: accept and classify items.
  mtcg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_data      (in_data),
    .in_stall     (in_stall),
    .route_select (route_select),
    .q_full       (q_full),
    .push         (push),
    .cmd          (push_cmd)
  );

  // Command queue between the two ends.
  mtcg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .pop_data  (pop_cmd),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back end: period, schedule and byte output.
  mtcg_back #(
    .MAX_CLOCKS_PER_ITEM (MAX_CLOCKS_PER_ITEM)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .q_empty           (q_empty),
    .q_data            (pop_cmd),
    .pop               (pop),
    .tempo_bpm         (tempo_bpm),
    .ratio_numerator   (ratio_numerator),
    .ratio_denominator (ratio_denominator),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_data          (out_data)
  );

`ifndef ASSERT_OFF
  // Suppressed items never reach the queue.
  a_push_active: assert property (@(posedge clk) disable iff (rst)
    push |-> (route_select != 2'd0) && !in_data.external_sync)
    else $error("suppressed item entered the command queue");

  // A Stop byte always closes its item.
  a_stop_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status_byte == mtcg_pkg::ST_STOP)) |-> out_data.last)
    else $error("stop byte not marked last");

  // Start or Continue is always followed by at least one clock.
  a_start_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ((out_data.status_byte == mtcg_pkg::ST_START) ||
                   (out_data.status_byte == mtcg_pkg::ST_CONTINUE))) |-> !out_data.last)
    else $error("start or continue byte marked last");
`endif

endmodule
`default_nettype wire
